// File: rtl/core/sssp_pkg.sv
package sssp_pkg;

    localparam int NODE_BITS        = 6;
    localparam int DIST_BITS        = 27;
    localparam int NODE_COUNT_BITS  = 7;
    localparam int EDGE_WEIGHT_BITS = 20;

    localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;
    localparam logic [DIST_BITS-1:0]       UNREACHED        = 27'd100000000;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_RUN      = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    // Status codes of a result.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD_START  = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic [NODE_BITS-1:0] from_node;
        logic [NODE_BITS-1:0] to_node;
        logic [15:0]          weight;
        logic [NODE_BITS-1:0] start_node;
    } in_item_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] node_index;
        logic [DIST_BITS-1:0] distance;
        logic                 last;
        logic [1:0]           status;
    } out_item_t;

    // Command from the sequencer to the edge table.
    typedef struct packed {
        logic                 wr;
        logic                 clr;
        logic [NODE_BITS-1:0] from_node;
        logic [NODE_BITS-1:0] to_node;
        logic [15:0]          weight;
    } edge_cmd_t;

    // One stored edge as seen by the sequencer, weight zero-extended.
    typedef struct packed {
        logic [NODE_BITS-1:0]        from_node;
        logic [NODE_BITS-1:0]        to_node;
        logic [EDGE_WEIGHT_BITS-1:0] weight;
    } edge_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACK,
        S_INIT,
        S_SCAN,
        S_SETTLE,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_RELAX,
        S_OUT_RD,
        S_OUT_PUT
    } state_e;

endpackage

// File: rtl/core/sssp_ram.sv
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sssp_edge_table.sv
module sssp_edge_table #(
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16,
    localparam int EAW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ECW        = $clog2(MAX_EDGES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sssp_pkg::edge_cmd_t  cmd,
    input  logic                 rd_en,
    input  logic [EAW-1:0]       rd_addr,
    output sssp_pkg::edge_entry_t rd_entry,
    output logic [ECW-1:0]       count,
    output logic                 full
);

    localparam int NB = sssp_pkg::NODE_BITS;
    localparam int EW = 2 * NB + WEIGHT_BITS;

    logic [ECW-1:0] count_reg;
    logic [ECW-1:0] count_next;
    logic           wr_en;
    logic [EW-1:0]  wr_data;
    logic [EW-1:0]  rd_data;

    assign full    = (count_reg == ECW'(MAX_EDGES));
    assign wr_en   = cmd.wr && !full;
    assign wr_data = {cmd.from_node, cmd.to_node, WEIGHT_BITS'(cmd.weight)};

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + ECW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    sssp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[EAW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry.from_node = rd_data[EW-1 -: NB];
    assign rd_entry.to_node   = rd_data[WEIGHT_BITS +: NB];
    assign rd_entry.weight    = sssp_pkg::EDGE_WEIGHT_BITS'(rd_data[WEIGHT_BITS-1:0]);
    assign count              = count_reg;

endmodule

// File: rtl/core/sssp_engine.sv
module sssp_engine #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16,
    localparam int NAW        = $clog2(MAX_NODES),
    localparam int NCW        = $clog2(MAX_NODES + 1),
    localparam int EAW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ECW        = $clog2(MAX_EDGES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  sssp_pkg::in_item_t    in_item,
    output logic                  ready,
    input  logic [NCW-1:0]        node_limit,
    output sssp_pkg::edge_cmd_t   edge_cmd,
    output logic                  edge_rd_en,
    output logic [EAW-1:0]        edge_rd_addr,
    input  sssp_pkg::edge_entry_t edge_entry,
    input  logic [ECW-1:0]        edge_count,
    input  logic                  edge_full,
    output logic                  res_valid,
    output sssp_pkg::out_item_t   res,
    input  logic                  res_ready
);

    localparam int DB = sssp_pkg::DIST_BITS;
    localparam int CB = sssp_pkg::NODE_COUNT_BITS;
    localparam int NB = sssp_pkg::NODE_BITS;

    sssp_pkg::state_e state_reg, state_next;

    logic [NCW-1:0]         n_reg, n_next;
    logic [NB-1:0]          start_reg, start_next;
    logic [NCW-1:0]         cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [NAW-1:0]         pend_idx_reg, pend_idx_next;
    logic                   found_reg, found_next;
    logic [NAW-1:0]         pick_reg, pick_next;
    logic [DB-1:0]          pick_d_reg, pick_d_next;
    logic [ECW-1:0]         edge_idx_reg, edge_idx_next;
    logic [NAW-1:0]         dst_reg, dst_next;
    logic [WEIGHT_BITS-1:0] wt_reg, wt_next;
    logic [1:0]             status_reg, status_next;

    // Distance store: settled flag on top of the distance.
    logic              dist_wr_en;
    logic [NAW-1:0]    dist_wr_addr;
    logic [DB:0]       dist_wr_data;
    logic              dist_rd_en;
    logic [NAW-1:0]    dist_rd_addr;
    logic [DB:0]       dist_rd_data;

    logic [DB:0]       cand;
    logic              cnt_in_range;
    logic              out_last;

    assign cand         = {1'b0, pick_d_reg} + (DB + 1)'(wt_reg);
    assign cnt_in_range = (cnt_reg < n_reg);
    assign out_last     = ((cnt_reg + NCW'(1)) == n_reg);

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        start_next    = start_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        pick_d_next   = pick_d_reg;
        edge_idx_next = edge_idx_reg;
        dst_next      = dst_reg;
        wt_next       = wt_reg;
        status_next   = status_reg;

        ready         = 1'b0;
        edge_cmd      = '0;
        edge_rd_en    = 1'b0;
        edge_rd_addr  = edge_idx_reg[EAW-1:0];
        dist_wr_en    = 1'b0;
        dist_wr_addr  = cnt_reg[NAW-1:0];
        dist_wr_data  = '0;
        dist_rd_en    = 1'b0;
        dist_rd_addr  = cnt_reg[NAW-1:0];
        res_valid     = 1'b0;
        res           = '0;

        unique case (state_reg)
            sssp_pkg::S_IDLE:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    case (in_item.op)
                        sssp_pkg::OP_ADD_EDGE:
                        begin
                            edge_cmd.wr        = 1'b1;
                            edge_cmd.from_node = in_item.from_node;
                            edge_cmd.to_node   = in_item.to_node;
                            edge_cmd.weight    = in_item.weight;
                            status_next = edge_full ? sssp_pkg::STATUS_TABLE_FULL
                                                    : sssp_pkg::STATUS_OK;
                            state_next  = sssp_pkg::S_ACK;
                        end
                        sssp_pkg::OP_CLEAR:
                        begin
                            edge_cmd.clr = 1'b1;
                            status_next  = sssp_pkg::STATUS_OK;
                            state_next   = sssp_pkg::S_ACK;
                        end
                        sssp_pkg::OP_RUN:
                        begin
                            if (CB'(in_item.start_node) >= CB'(node_limit))
                            begin
                                status_next = sssp_pkg::STATUS_BAD_START;
                                state_next  = sssp_pkg::S_ACK;
                            end
                            else
                            begin
                                n_next     = node_limit;
                                start_next = in_item.start_node;
                                cnt_next   = '0;
                                state_next = sssp_pkg::S_INIT;
                            end
                        end
                        default:
                        begin
                            state_next = sssp_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            sssp_pkg::S_ACK:
            begin
                res_valid     = 1'b1;
                res.last      = 1'b1;
                res.status    = status_reg;
                if (res_ready)
                begin
                    state_next = sssp_pkg::S_IDLE;
                end
            end

            sssp_pkg::S_INIT:
            begin
                dist_wr_en   = 1'b1;
                dist_wr_data = {1'b0, (CB'(cnt_reg) == CB'(start_reg)) ? '0
                                                                       : sssp_pkg::UNREACHED};
                cnt_next     = cnt_reg + NCW'(1);
                if (out_last)
                begin
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    pick_d_next = sssp_pkg::UNREACHED;
                    state_next  = sssp_pkg::S_SCAN;
                end
            end

            sssp_pkg::S_SCAN:
            begin
                // Reads are issued one a cycle; each result is compared in the cycle after its read.
                if (cnt_in_range)
                begin
                    dist_rd_en    = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[NAW-1:0];
                    cnt_next      = cnt_reg + NCW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && !dist_rd_data[DB] && (dist_rd_data[DB-1:0] < pick_d_reg))
                begin
                    found_next  = 1'b1;
                    pick_next   = pend_idx_reg;
                    pick_d_next = dist_rd_data[DB-1:0];
                end
                if (!cnt_in_range && !pend_reg)
                begin
                    cnt_next = '0;
                    if (found_reg)
                    begin
                        state_next = sssp_pkg::S_SETTLE;
                    end
                    else
                    begin
                        state_next = sssp_pkg::S_OUT_RD;
                    end
                end
            end

            sssp_pkg::S_SETTLE:
            begin
                dist_wr_en    = 1'b1;
                dist_wr_addr  = pick_reg;
                dist_wr_data  = {1'b1, pick_d_reg};
                edge_idx_next = '0;
                state_next    = sssp_pkg::S_EDGE_RD;
            end

            sssp_pkg::S_EDGE_RD:
            begin
                if (edge_idx_reg < edge_count)
                begin
                    edge_rd_en = 1'b1;
                    state_next = sssp_pkg::S_EDGE_CHK;
                end
                else
                begin
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    pick_d_next = sssp_pkg::UNREACHED;
                    state_next  = sssp_pkg::S_SCAN;
                end
            end

            sssp_pkg::S_EDGE_CHK:
            begin
                if ((edge_entry.from_node == NB'(pick_reg)) &&
                    (CB'(edge_entry.to_node) < CB'(n_reg)))
                begin
                    dist_rd_en   = 1'b1;
                    dist_rd_addr = edge_entry.to_node[NAW-1:0];
                    dst_next     = edge_entry.to_node[NAW-1:0];
                    wt_next      = edge_entry.weight[WEIGHT_BITS-1:0];
                    state_next   = sssp_pkg::S_RELAX;
                end
                else
                begin
                    edge_idx_next = edge_idx_reg + ECW'(1);
                    state_next    = sssp_pkg::S_EDGE_RD;
                end
            end

            sssp_pkg::S_RELAX:
            begin
                if ((cand < (DB + 1)'(sssp_pkg::UNREACHED)) &&
                    (cand < {1'b0, dist_rd_data[DB-1:0]}))
                begin
                    dist_wr_en   = 1'b1;
                    dist_wr_addr = dst_reg;
                    dist_wr_data = {dist_rd_data[DB], cand[DB-1:0]};
                end
                edge_idx_next = edge_idx_reg + ECW'(1);
                state_next    = sssp_pkg::S_EDGE_RD;
            end

            sssp_pkg::S_OUT_RD:
            begin
                dist_rd_en = 1'b1;
                state_next = sssp_pkg::S_OUT_PUT;
            end

            sssp_pkg::S_OUT_PUT:
            begin
                res_valid      = 1'b1;
                res.node_index = NB'(cnt_reg);
                res.distance   = dist_rd_data[DB-1:0];
                res.last       = out_last;
                res.status     = sssp_pkg::STATUS_OK;
                if (res_ready)
                begin
                    if (out_last)
                    begin
                        state_next = sssp_pkg::S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + NCW'(1);
                        state_next = sssp_pkg::S_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = sssp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sssp_pkg::S_IDLE;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        start_reg    <= start_next;
        cnt_reg      <= cnt_next;
        pend_idx_reg <= pend_idx_next;
        pick_reg     <= pick_next;
        pick_d_reg   <= pick_d_next;
        edge_idx_reg <= edge_idx_next;
        dst_reg      <= dst_next;
        wt_reg       <= wt_next;
        status_reg   <= status_next;
    end

    sssp_ram #(
        .WIDTH (DB + 1),
        .DEPTH (MAX_NODES)
    ) u_dist_ram (
        .clk     (clk),
        .wr_en   (dist_wr_en),
        .wr_addr (dist_wr_addr),
        .wr_data (dist_wr_data),
        .rd_en   (dist_rd_en),
        .rd_addr (dist_rd_addr),
        .rd_data (dist_rd_data)
    );

endmodule

// File: rtl/core/single_source_shortest_paths.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  in_item (op, edges, start node)
// out       output     out_valid/out_stall out_item (node, distance, last, status)
// cfg       input      cfg_valid/cfg_ready cfg_data (node_count)
//
// An add-edge, clear or refused run transaction gets its result through the acknowledge
// state and the output register; the next input is taken once the engine is idle again.
// A run holds in_stall high while it initialises the distances of all configured nodes,
// then for each settled node scans the configured nodes and walks the stored edges, relaxing
// the edges that leave the settled node toward a node in range, and reads out the
// distances; out stalling while a result waits lengthens it. The run time is set by the
// single read port of the distance memory, which the min-scan and every relaxation share.
// Reset clears the edge count and sets node_count to 64; no memory is swept.
module single_source_shortest_paths #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sssp_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output sssp_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [sssp_pkg::NODE_COUNT_BITS-1:0] cfg_data
);

    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int CB  = sssp_pkg::NODE_COUNT_BITS;

    // The node count register; the user must write configuration only while idle, the block does not enforce it.
    logic [CB-1:0]  node_count_reg;
    logic [NCW-1:0] node_limit;

    // Output register that decouples the sequencer from the downstream stall.
    logic                out_valid_reg;
    sssp_pkg::out_item_t out_item_reg;
    logic                slot_free;

    sssp_pkg::edge_cmd_t   edge_cmd;
    logic                  edge_rd_en;
    logic [EAW-1:0]        edge_rd_addr;
    sssp_pkg::edge_entry_t edge_entry;
    logic [ECW-1:0]        edge_count;
    logic                  edge_full;

    logic                  eng_ready;
    logic                  res_valid;
    sssp_pkg::out_item_t   res;

    assign cfg_ready = 1'b1;

    // Counts above the supported node count are capped.
    assign node_limit = (node_count_reg > CB'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                          : NCW'(node_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= sssp_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // The register can take a new result when empty or when its content leaves now.
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = !eng_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    sssp_edge_table #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_edge_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (edge_cmd),
        .rd_en    (edge_rd_en),
        .rd_addr  (edge_rd_addr),
        .rd_entry (edge_entry),
        .count    (edge_count),
        .full     (edge_full)
    );

    sssp_engine #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_item      (in_item),
        .ready        (eng_ready),
        .node_limit   (node_limit),
        .edge_cmd     (edge_cmd),
        .edge_rd_en   (edge_rd_en),
        .edge_rd_addr (edge_rd_addr),
        .edge_entry   (edge_entry),
        .edge_count   (edge_count),
        .edge_full    (edge_full),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (slot_free)
    );

endmodule

// File: sim/tb_single_source_shortest_paths.sv
`timescale 1ns / 1ps

module tb_single_source_shortest_paths;

    // The block is built with its default sizes, and the prediction below uses the same ones.
    localparam int NODE_SLOTS  = 64;
    localparam int EDGE_SLOTS  = 256;
    localparam int COST_BITS   = 16;

    localparam int NODE_W  = sssp_pkg::NODE_BITS;
    localparam int COUNT_W = sssp_pkg::NODE_COUNT_BITS;
    localparam int DIST_W  = sssp_pkg::DIST_BITS;

    // The op code that the block has no use for. It must be swallowed without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles to let pass after the last expected result before the block counts as idle.
    // An ignored transaction has no result to wait for, so this covers its latency.
    localparam int SETTLE_CYCLES = 40;

    // A cap on the whole test, set well above its length even if every run settled all 64 nodes.
    localparam int CYCLE_LIMIT = 10_000_000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    sssp_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    sssp_pkg::out_item_t out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data = '0;

    // Commands waiting to be offered to the block, and results the graph says must come back.
    sssp_pkg::in_item_t  graph_commands[$];
    sssp_pkg::out_item_t due_results[$];

    // Our own copy of the block's state: the edge table, its fill level and the node count.
    logic [NODE_W-1:0]    edge_tail [EDGE_SLOTS];
    logic [NODE_W-1:0]    edge_head [EDGE_SLOTS];
    logic [COST_BITS-1:0] edge_cost [EDGE_SLOTS];
    int unsigned          edge_total = 0;
    logic [COUNT_W-1:0]   node_limit = sssp_pkg::NODE_COUNT_RESET;

    int unsigned error_count = 0;
    int unsigned cycles = 0;
    int unsigned queued_items = 0;
    bit          idling_on = 1'b1;
    bit          in_fire = 1'b0;
    int unsigned in_gap = 0;
    int unsigned stall_left = 0;

    single_source_shortest_paths #(
        .MAX_NODES   (NODE_SLOTS),
        .MAX_EDGES   (EDGE_SLOTS),
        .WEIGHT_BITS (COST_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Every mismatch goes through here. Printing stops after a hundred lines so that a
    // badly broken block cannot flood the log, but the count keeps going.
    task automatic flag_error(input string msg);
        if (error_count < 100)
        begin
            $display("ERROR at cycle %0d: %s", cycles, msg);
        end
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Appends one expected result at the back of the list.
    task automatic add_due(input sssp_pkg::out_item_t res);
        due_results.insert(due_results.size(), res);
    endtask

    // Works out what one accepted transaction must produce and updates our copy of the state.
    // A run settles nodes by a min-scan over the unsettled ones, lowest index first on a tie,
    // and relaxes every stored edge that leaves the settled node and lands inside the graph.
    task automatic shortest_path_step(input sssp_pkg::in_item_t item);
        int unsigned         limit;
        int unsigned         reach [NODE_SLOTS];
        bit                  fixed [NODE_SLOTS];
        int unsigned         pick;
        int unsigned         pick_d;
        int unsigned         cand;
        sssp_pkg::out_item_t res;
        limit = (node_limit > NODE_SLOTS) ? NODE_SLOTS : node_limit;
        res = '0;
        res.last = 1'b1;
        res.status = sssp_pkg::STATUS_OK;
        case (item.op)
            sssp_pkg::OP_ADD_EDGE:
            begin
                if (edge_total >= EDGE_SLOTS)
                begin
                    res.status = sssp_pkg::STATUS_TABLE_FULL;
                end
                else
                begin
                    // The edge is kept whatever its ends are; range is judged at run time.
                    edge_tail[edge_total] = item.from_node;
                    edge_head[edge_total] = item.to_node;
                    edge_cost[edge_total] = item.weight[COST_BITS-1:0];
                    edge_total++;
                end
                add_due(res);
            end
            sssp_pkg::OP_CLEAR:
            begin
                edge_total = 0;
                add_due(res);
            end
            sssp_pkg::OP_RUN:
            begin
                if (item.start_node >= limit)
                begin
                    // A node count of zero lands here for every start node.
                    res.status = sssp_pkg::STATUS_BAD_START;
                    add_due(res);
                end
                else
                begin
                    for (int i = 0; i < limit; i++)
                    begin
                        reach[i] = sssp_pkg::UNREACHED;
                        fixed[i] = 1'b0;
                    end
                    reach[item.start_node] = 0;
                    for (int round = 0; round < limit; round++)
                    begin
                        pick = limit;
                        pick_d = sssp_pkg::UNREACHED;
                        for (int i = 0; i < limit; i++)
                        begin
                            if (!fixed[i] && reach[i] < pick_d)
                            begin
                                pick = i;
                                pick_d = reach[i];
                            end
                        end
                        // Once nothing reachable is left, the later rounds find nothing either.
                        if (pick < limit)
                        begin
                            fixed[pick] = 1'b1;
                            for (int e = 0; e < edge_total; e++)
                            begin
                                if (edge_tail[e] == pick && edge_head[e] < limit)
                                begin
                                    cand = pick_d + edge_cost[e];
                                    // A path that reaches the unreached mark is never taken.
                                    if (cand < sssp_pkg::UNREACHED && cand < reach[edge_head[e]])
                                    begin
                                        reach[edge_head[e]] = cand;
                                    end
                                end
                            end
                        end
                    end
                    for (int i = 0; i < limit; i++)
                    begin
                        res.node_index = NODE_W'(i);
                        res.distance = DIST_W'(reach[i]);
                        res.last = (i + 1 == limit);
                        res.status = sssp_pkg::STATUS_OK;
                        add_due(res);
                    end
                end
            end
            default:
            begin
                // The unused op changes nothing and answers nothing.
            end
        endcase
    endtask

    // The monitor looks at both channels at the rising edge. An accepted input transaction
    // is fed to the prediction, and an accepted result is checked against the oldest
    // expectation field by field.
    always @(posedge clk or negedge rst_n)
    begin
        sssp_pkg::out_item_t want;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                shortest_path_step(in_item);
            end
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    flag_error("result transaction with no expectation waiting");
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("node_index", out_item.node_index, want.node_index);
                    compare_field("distance", out_item.distance, want.distance);
                    compare_field("last", out_item.last, want.last);
                    compare_field("status", out_item.status, want.status);
                end
            end
        end
    end

    // The driver moves to the next command at the falling edge once the current one has been
    // taken. A stalled transaction stays on the bus unchanged. After a command it sometimes
    // leaves the bus empty for a short burst.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (graph_commands.size() > 0)
            begin
                in_item <= graph_commands.pop_front();
                in_valid <= 1'b1;
                if (idling_on && $urandom_range(0, 4) == 0)
                begin
                    in_gap = $urandom_range(1, 7);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The result side holds the block off in bursts of random length.
    always @(negedge clk)
    begin
        if (!idling_on)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // A run that hangs must not hang the simulation.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic sssp_pkg::in_item_t random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(sssp_pkg::in_item_t)-1:0];
    endfunction

    // Fields a command does not use are filled with noise, which the block must ignore.
    function automatic sssp_pkg::in_item_t edge_item(input int unsigned tail,
                                                     input int unsigned head,
                                                     input int unsigned cost);
        sssp_pkg::in_item_t it;
        it = random_item();
        it.op = sssp_pkg::OP_ADD_EDGE;
        it.from_node = NODE_W'(tail);
        it.to_node = NODE_W'(head);
        it.weight = 16'(cost);
        return it;
    endfunction

    function automatic sssp_pkg::in_item_t run_item(input int unsigned start);
        sssp_pkg::in_item_t it;
        it = random_item();
        it.op = sssp_pkg::OP_RUN;
        it.start_node = NODE_W'(start);
        return it;
    endfunction

    function automatic sssp_pkg::in_item_t clear_item();
        sssp_pkg::in_item_t it;
        it = random_item();
        it.op = sssp_pkg::OP_CLEAR;
        return it;
    endfunction

    function automatic sssp_pkg::in_item_t unused_item();
        sssp_pkg::in_item_t it;
        it = random_item();
        it.op = OP_UNUSED;
        return it;
    endfunction

    // Picks a node mostly inside the graph, and now and then anywhere in the field's range.
    function automatic int unsigned pick_node(input int unsigned n, input int unsigned odds);
        if (n == 0 || $urandom_range(0, odds) == 0)
        begin
            return $urandom_range(0, NODE_SLOTS - 1);
        end
        return $urandom_range(0, n - 1);
    endfunction

    // Small weights make competing paths likely; large ones exercise the full field.
    function automatic int unsigned pick_weight();
        if ($urandom_range(0, 1) == 0)
        begin
            return $urandom_range(0, 15);
        end
        return $urandom_range(0, 65535);
    endfunction

    task automatic queue_item(input sssp_pkg::in_item_t item);
        graph_commands.insert(graph_commands.size(), item);
        if (item.op != OP_UNUSED)
        begin
            queued_items++;
        end
    endtask

    // Returns at a rising edge once every command is taken and every result has come,
    // plus a margin for a transaction that has nothing to answer.
    task automatic wait_for_quiet();
        while (graph_commands.size() != 0 || in_valid || due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The node count is only ever changed while the block is idle.
    task automatic write_node_count(input logic [COUNT_W-1:0] value);
        wait_for_quiet();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        node_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random phase: a new node count, usually a fresh table, then two rounds of edges
    // followed by runs. The table is cleared when it grows large so runs stay short.
    task automatic build_random_phase();
        logic [COUNT_W-1:0] count_value;
        int unsigned n;
        case ($urandom_range(0, 15))
            0:       count_value = '0;
            1:       count_value = COUNT_W'(1);
            2:       count_value = COUNT_W'($urandom_range(NODE_SLOTS + 1, 127));
            3:       count_value = COUNT_W'(NODE_SLOTS);
            default: count_value = COUNT_W'($urandom_range(2, 12));
        endcase
        write_node_count(count_value);
        n = (count_value > NODE_SLOTS) ? NODE_SLOTS : count_value;
        if (edge_total > 60 || $urandom_range(0, 3) != 0)
        begin
            queue_item(clear_item());
        end
        repeat (2)
        begin
            repeat ($urandom_range(0, 12))
            begin
                queue_item(edge_item(pick_node(n, 7), pick_node(n, 7), pick_weight()));
            end
            repeat ($urandom_range(1, 2))
            begin
                queue_item(run_item(pick_node(n, 5)));
            end
            if ($urandom_range(0, 5) == 0)
            begin
                queue_item(unused_item());
            end
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions at the reset node count of 64. The weights reach both ends
        // of the field, node 63 is both a tail and a head, and a self loop is included.
        queue_item(edge_item(0, 1, 0));
        queue_item(edge_item(1, 2, 65535));
        queue_item(edge_item(63, 0, 16'h5555));
        queue_item(edge_item(0, 63, 16'hAAAA));
        queue_item(edge_item(2, 2, 7));
        queue_item(edge_item(1, 3, 5));
        queue_item(edge_item(0, 3, 65535));
        queue_item(run_item(0));
        queue_item(run_item(63));
        // The unused op with every bit set must leave no trace.
        queue_item(sssp_pkg::in_item_t'('1));
        queue_item(clear_item());
        // With an empty table only the start node itself is reached.
        queue_item(run_item(5));

        // A single node: the edge to node 1 falls outside and starts above 0 are refused.
        write_node_count(COUNT_W'(1));
        queue_item(edge_item(0, 1, 3));
        queue_item(run_item(0));
        queue_item(run_item(1));
        queue_item(run_item(63));

        // No nodes at all: every run is refused.
        write_node_count('0);
        queue_item(run_item(0));

        // The largest count the register holds is capped to the graph size.
        write_node_count('1);
        queue_item(edge_item(3, 4, 1));
        queue_item(edge_item(4, 5, 2));
        queue_item(run_item(3));

        // Fill the table with a small graph, then overflow it and run on the full table.
        write_node_count(COUNT_W'(4));
        queue_item(clear_item());
        repeat (EDGE_SLOTS)
        begin
            queue_item(edge_item(pick_node(4, 7), pick_node(4, 7), pick_weight()));
        end
        queue_item(edge_item(0, 1, 1));
        queue_item(edge_item(2, 3, 1));
        queue_item(run_item(0));
        queue_item(run_item(3));
        queue_item(run_item(4));

        // At the largest size: a run of all nodes over a full table, then a clear and one more run.
        write_node_count(COUNT_W'(NODE_SLOTS));
        queue_item(run_item($urandom_range(0, NODE_SLOTS - 1)));
        queue_item(clear_item());
        queue_item(edge_item(0, 1, 9));
        queue_item(run_item(0));

        // Random phases fill up the total. The last stretch runs with neither side idling.
        wait_for_quiet();
        idling_on = 1'b0;
        while (queued_items < 300)
        begin
            wait_for_quiet();
            build_random_phase();
        end

        wait_for_quiet();
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
